@@ rtl/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and command codes for the SHA-1 message digest.
// ----------------------------------------------------------------------------
package sha1md_pkg;

   typedef logic [31:0] word_type;

   localparam int DIGEST_WORDS = 5;
   localparam int SCHED_WORDS  = 16;
   localparam int BLOCK_BYTES  = 64;
   localparam int PAD_LIMIT    = 56;
   localparam int ROUNDS       = 80;
   localparam int MAX_BYTES    = 4;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam word_type K_0 = 32'h5A827999;
   localparam word_type K_1 = 32'h6ED9EBA1;
   localparam word_type K_2 = 32'h8F1BBCDC;
   localparam word_type K_3 = 32'hCA62C1D6;

   localparam word_type H_INIT [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // input beat
   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        end_of_message;
   } req_type;

   // result beat
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // working variables a..e
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } vars_type;

   // round function group: choose, parity, majority, parity
   typedef enum logic [1:0] {
      PH_CHOOSE  = 2'd0,
      PH_PARITY1 = 2'd1,
      PH_MAJOR   = 2'd2,
      PH_PARITY2 = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      SCH_HOLD,
      SCH_INSERT,
      SCH_PAD,
      SCH_LENGTH,
      SCH_ROUND
   } sched_op_type;

   // command from the sequencer to the schedule file
   typedef struct packed {
      sched_op_type op;
      logic [5:0]   fill;
      logic [2:0]   count;
      logic [31:0]  data;
      logic         put_len;
      logic         expand;
      logic [63:0]  length;
   } sched_cmd_type;

endpackage

@@ rtl/sha1md_round.sv @@
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 round: round function, constant select and the five-way add.
// ----------------------------------------------------------------------------
module sha1md_round
   import sha1md_pkg::*;
(
   input  vars_type  vars,
   input  word_type  w,
   input  phase_type phase,
   output vars_type  vars_next
);

   word_type f;
   word_type k;
   word_type a_rot;

   always_comb begin
      case (phase)
         PH_CHOOSE: begin
            f = (vars.b & vars.c) | (~vars.b & vars.d);
            k = K_0;
         end
         PH_PARITY1: begin
            f = vars.b ^ vars.c ^ vars.d;
            k = K_1;
         end
         PH_MAJOR: begin
            f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
            k = K_2;
         end
         default: begin
            f = vars.b ^ vars.c ^ vars.d;
            k = K_3;
         end
      endcase
   end

   assign a_rot = {vars.a[26:0], vars.a[31:27]};

   assign vars_next.a = a_rot + f + vars.e + k + w;
   assign vars_next.b = vars.a;
   assign vars_next.c = {vars.b[1:0], vars.b[31:2]};
   assign vars_next.d = vars.c;
   assign vars_next.e = vars.d;

endmodule

@@ rtl/sha1md_sched.sv @@
// ----------------------------------------------------------------------------
// sha1md_sched
// 16-word block / message schedule: byte packing, padding, length insert,
// and the sliding window that expands the schedule one word per round.
// ----------------------------------------------------------------------------
module sha1md_sched
   import sha1md_pkg::*;
(
   input  logic          clock,
   input  sched_cmd_type cmd,
   output word_type      w
);

   word_type sreg_ff [SCHED_WORDS];
   word_type sreg_in [SCHED_WORDS];
   word_type w_exp;

   // window: sreg_ff[0] is the oldest word, taps at 0, 2, 8, 13
   assign w_exp = sreg_ff[13] ^ sreg_ff[8] ^ sreg_ff[2] ^ sreg_ff[0];
   assign w     = cmd.expand ? {w_exp[30:0], w_exp[31]} : sreg_ff[0];

   always_comb begin
      logic [6:0] p;
      logic [4:0] sh;
      logic [5:0] pos;
      sreg_in = sreg_ff;
      p       = '0;
      sh      = '0;
      pos     = '0;
      case (cmd.op)
         SCH_INSERT: begin
            for (int k = 0; k < MAX_BYTES; k++) begin
               p  = {1'b0, cmd.fill} + 7'(k);
               sh = {~p[1:0], 3'b000};
               if (3'(k) < cmd.count && p < 7'(BLOCK_BYTES)) begin
                  sreg_in[p[5:2]][sh +: 8] = cmd.data[31 - 8*k -: 8];
               end
            end
         end
         SCH_PAD: begin
            for (int i = 0; i < SCHED_WORDS; i++) begin
               for (int j = 0; j < 4; j++) begin
                  pos = 6'(4*i + j);
                  if (pos == cmd.fill) begin
                     sreg_in[i][8*(3-j) +: 8] = PAD_BYTE;
                  end else if (pos > cmd.fill) begin
                     sreg_in[i][8*(3-j) +: 8] = 8'h00;
                  end
               end
            end
            if (cmd.put_len) begin
               sreg_in[SCHED_WORDS-2] = cmd.length[63:32];
               sreg_in[SCHED_WORDS-1] = cmd.length[31:0];
            end
         end
         SCH_LENGTH: begin
            for (int i = 0; i < SCHED_WORDS; i++) begin
               sreg_in[i] = '0;
            end
            sreg_in[SCHED_WORDS-2] = cmd.length[63:32];
            sreg_in[SCHED_WORDS-1] = cmd.length[31:0];
         end
         SCH_ROUND: begin
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
               sreg_in[i] = sreg_ff[i+1];
            end
            sreg_in[SCHED_WORDS-1] = w;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SCHED_WORDS; i++) begin
         sreg_ff[i] <= sreg_in[i];
      end
   end

endmodule

@@ rtl/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a stream of big-endian words; emits the five digest words at
// the end of each message and then starts over from the initial hash.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_ready  req_type: data_word, valid_bytes,
//                                             end_of_message
//  rsp_     out        rsp_valid / rsp_ready  rsp_type: digest_word, word_index,
//                                             last_word
//
// Sequence: a word that does not complete a block is accepted, then packed.
//   A word that completes a block also runs the rounds on the shared round
//   unit and a chaining add, then returns to pack the rest of the word.
//   End of message: a pad step plus one compression, or two compressions
//   plus a length step when 56 or more bytes are pending, then 5 result
//   beats. A new word is taken only in idle, once the last one is done.
// Reset: synchronous, active high; clears the sequencer, fill count, bit
//   length and chaining value. Schedule and round registers are not reset.
// Stalls: req_ready is high only in idle. The digest beats are shown from
//   the chaining registers and hold while rsp_ready is low.
// ----------------------------------------------------------------------------
module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_PAD,
      S_LEN,
      S_ROUND,
      S_ADD,
      S_EMIT
   } state_type;

   // where to go after a compression
   typedef enum logic [1:0] {
      RET_INSERT,
      RET_LEN,
      RET_EMIT
   } ret_type;

   localparam logic [2:0] LAST_INDEX = 3'(DIGEST_WORDS - 1);

   state_type     state_ff, state_in;
   ret_type       ret_ff, ret_in;
   logic [31:0]   data_ff, data_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          last_ff, last_in;
   logic [5:0]    fill_ff, fill_in;
   logic [63:0]   len_ff, len_in;
   logic [6:0]    round_ff, round_in;
   logic [2:0]    idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   vars_type      vars_ff, vars_in;
   word_type      chain_ff [DIGEST_WORDS];
   word_type      chain_in [DIGEST_WORDS];

   sched_cmd_type cmd;
   word_type      w;
   phase_type     phase;
   vars_type      vars_next;
   vars_type      chain_vars;

   logic [6:0]    room;
   logic [2:0]    take;
   logic          wrap;

   sha1md_sched u_sched (
      .clock (clock),
      .cmd   (cmd),
      .w     (w)
   );

   sha1md_round u_round (
      .vars      (vars_ff),
      .w         (w),
      .phase     (phase),
      .vars_next (vars_next)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign rsp_data.digest_word = chain_ff[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = (idx_ff == LAST_INDEX);

   assign chain_vars = {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3], chain_ff[4]};

   // room left in the block and bytes packed this cycle
   assign room = 7'(BLOCK_BYTES) - {1'b0, fill_ff};
   assign wrap = ({4'b0, cnt_ff} >= room);
   assign take = wrap ? room[2:0] : cnt_ff;

   always_comb begin
      if (round_ff < 7'd20)      phase = PH_CHOOSE;
      else if (round_ff < 7'd40) phase = PH_PARITY1;
      else if (round_ff < 7'd60) phase = PH_MAJOR;
      else                       phase = PH_PARITY2;
   end

   always_comb begin
      cmd.op      = SCH_HOLD;
      cmd.fill    = fill_ff;
      cmd.count   = take;
      cmd.data    = data_ff;
      cmd.put_len = (fill_ff < 6'(PAD_LIMIT));
      cmd.expand  = (round_ff >= 7'(SCHED_WORDS));
      cmd.length  = len_ff;
      unique case (state_ff)
         S_INSERT: cmd.op = SCH_INSERT;
         S_PAD:    cmd.op = SCH_PAD;
         S_LEN:    cmd.op = SCH_LENGTH;
         S_ROUND:  cmd.op = SCH_ROUND;
         default:  cmd.op = SCH_HOLD;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      data_in      = data_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      vars_in      = vars_ff;
      chain_in     = chain_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               data_in  = req_data.data_word;
               cnt_in   = (req_data.valid_bytes > 3'(MAX_BYTES)) ? 3'(MAX_BYTES)
                                                                 : req_data.valid_bytes;
               last_in  = req_data.end_of_message;
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            fill_in = fill_ff + 6'(take);
            len_in  = len_ff + {58'b0, take, 3'b000};
            data_in = data_ff << {take, 3'b000};
            cnt_in  = cnt_ff - take;
            if (wrap) begin
               // block full: compress, then finish the rest of this word
               vars_in  = chain_vars;
               round_in = '0;
               ret_in   = RET_INSERT;
               state_in = S_ROUND;
            end else if (last_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            vars_in  = chain_vars;
            round_in = '0;
            ret_in   = (fill_ff < 6'(PAD_LIMIT)) ? RET_EMIT : RET_LEN;
            state_in = S_ROUND;
         end
         S_LEN: begin
            vars_in  = chain_vars;
            round_in = '0;
            ret_in   = RET_EMIT;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            vars_in  = vars_next;
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(ROUNDS - 1)) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            chain_in[0] = chain_ff[0] + vars_ff.a;
            chain_in[1] = chain_ff[1] + vars_ff.b;
            chain_in[2] = chain_ff[2] + vars_ff.c;
            chain_in[3] = chain_ff[3] + vars_ff.d;
            chain_in[4] = chain_ff[4] + vars_ff.e;
            unique case (ret_ff)
               RET_INSERT: state_in = S_INSERT;
               RET_LEN:    state_in = S_LEN;
               default: begin
                  state_in     = S_EMIT;
                  rsp_valid_in = 1'b1;
                  idx_in       = '0;
                  fill_in      = '0;
                  len_in       = '0;
               end
            endcase
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (idx_ff == LAST_INDEX) begin
                  chain_in     = H_INIT;
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= RET_INSERT;
         fill_ff      <= '0;
         len_ff       <= '0;
         round_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= H_INIT;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         round_ff     <= round_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      vars_ff <= vars_in;
   end

   // no input taken while digest beats are pending
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high while digest beats pending");

   // an accepted beat always keeps the block busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("block not busy after accepted input beat");

   // final digest beat ends the result burst
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_word) |=> (!rsp_valid && req_ready))
      else $error("result burst did not end after last digest beat");

   // round counter stays in range during compression
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (round_ff < 7'(ROUNDS)))
      else $error("round counter out of range");

   // first and last chaining words restart from the initial hash after a message
   a_chain_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_word) |=>
         (chain_ff[0] == H_INIT[0] && chain_ff[4] == H_INIT[4]))
      else $error("chaining value not restored after digest");

endmodule
